[rtl/core/bre_pkg.sv]
// ----------------------------------------------------------------------------
// bre_pkg
// Shared types and constants for the breadth-first reachability engine.
// ----------------------------------------------------------------------------
package bre_pkg;

    localparam int VCOUNT_W = 9;
    localparam int VERTEX_W = 8;
    localparam int COUNT_W  = 8;
    localparam int STATUS_W = 2;

    localparam int DEF_MAX_VERTICES = 256;
    localparam int DEF_MAX_DEGREE   = 8;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd256;

    localparam logic FUNC_ADD_EDGE = 1'b0;
    localparam logic FUNC_SEARCH   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic                func;
        logic [VERTEX_W-1:0] from_vertex;
        logic [VERTEX_W-1:0] to_vertex;
        logic [VERTEX_W-1:0] source_vertex;
    } bre_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  reached_count;
        logic [STATUS_W-1:0] status;
    } bre_out_t;

    // controller to datapath
    typedef struct packed {
        logic clr_init;
        logic load;
        logic set_oor;
        logic edge_rd;
        logic edge_wr;
        logic start;
        logic pop;
        logic deg_rd;
        logic nb_init;
        logic nb_rd;
        logic vis_rd;
        logic visit;
        logic clr_rd;
        logic clr_wr;
        logic out_load;
    } bre_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic init_done;
        logic item_func;
        logic item_oor;
        logic queue_empty;
        logic nb_done;
        logic w_oor;
        logic clr_done;
        logic out_free;
    } bre_sts_t;

endpackage

[rtl/core/bre_datapath.sv]
// ----------------------------------------------------------------------------
// bre_datapath
// Graph stores, search queue, counters and result registers.
// ----------------------------------------------------------------------------
module bre_datapath
    import bre_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = DEF_MAX_DEGREE
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bre_cmd_t            cmd,
    output bre_sts_t            sts,
    input  bre_in_t             in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bre_out_t            out_data,
    input  logic                cfg_valid,
    input  logic [VCOUNT_W-1:0] cfg_data
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int QW = $clog2(MAX_VERTICES + 1);
    localparam int KW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int AW = VW + KW;
    localparam int NBR_DEPTH = MAX_VERTICES << KW;

    logic [VERTEX_W-1:0] nbr_mem [NBR_DEPTH];
    logic [DW-1:0]       deg_mem [MAX_VERTICES];
    logic                vis_mem [MAX_VERTICES];
    logic [VW-1:0]       que_mem [MAX_VERTICES];

    logic [VERTEX_W-1:0] nbr_q;
    logic [DW-1:0]       deg_q;
    logic                vis_q;
    logic [VW-1:0]       que_q;

    logic [VCOUNT_W-1:0] vcount_reg;
    bre_in_t             item_reg;
    logic [QW-1:0]       head_reg, head_next;
    logic [QW-1:0]       tail_reg, tail_next;
    logic [QW-1:0]       sweep_reg, sweep_next;
    logic [VW-1:0]       u_reg;
    logic [DW-1:0]       degu_reg;
    logic [DW-1:0]       k_reg, k_next;
    logic [VERTEX_W-1:0] w_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    bre_out_t            out_reg;

    logic [VCOUNT_W-1:0] n_eff;
    logic                from_oor, to_oor, src_oor;
    logic [VW-1:0]       from_idx, src_idx, w_idx;
    logic                deg_full;
    logic                do_visit;

    logic                nbr_we;
    logic [AW-1:0]       nbr_waddr;
    logic                deg_we, deg_re;
    logic [VW-1:0]       deg_waddr, deg_raddr;
    logic [DW-1:0]       deg_wdata;
    logic                vis_we;
    logic [VW-1:0]       vis_waddr;
    logic                vis_wdata;
    logic                que_we, que_re;
    logic [VW-1:0]       que_waddr, que_raddr;
    logic [VW-1:0]       que_wdata;

    assign n_eff = (32'(vcount_reg) > MAX_VERTICES) ? VCOUNT_W'(MAX_VERTICES) : vcount_reg;

    assign from_oor = {1'b0, item_reg.from_vertex}   >= n_eff;
    assign to_oor   = {1'b0, item_reg.to_vertex}     >= n_eff;
    assign src_oor  = {1'b0, item_reg.source_vertex} >= n_eff;
    assign from_idx = VW'(item_reg.from_vertex);
    assign src_idx  = VW'(item_reg.source_vertex);
    assign w_idx    = VW'(w_reg);
    assign deg_full = deg_q >= DW'(MAX_DEGREE);
    assign do_visit = cmd.visit && !vis_q;

    always_comb
    begin
        sts.init_done   = sweep_reg == QW'(MAX_VERTICES - 1);
        sts.item_func   = item_reg.func;
        sts.item_oor    = (item_reg.func == FUNC_SEARCH) ? src_oor : (from_oor || to_oor);
        sts.queue_empty = head_reg == tail_reg;
        sts.nb_done     = k_reg >= degu_reg;
        sts.w_oor       = {1'b0, nbr_q} >= n_eff;
        sts.clr_done    = sweep_reg == tail_reg;
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    // memory port selection
    always_comb
    begin
        nbr_we    = cmd.edge_wr && !deg_full;
        nbr_waddr = {from_idx, deg_q[KW-1:0]};

        deg_we    = cmd.clr_init || (cmd.edge_wr && !deg_full);
        deg_waddr = cmd.clr_init ? sweep_reg[VW-1:0] : from_idx;
        deg_wdata = cmd.clr_init ? '0 : deg_q + DW'(1);
        deg_re    = cmd.edge_rd || cmd.deg_rd;
        deg_raddr = cmd.deg_rd ? que_q : from_idx;

        vis_we    = cmd.clr_init || cmd.start || do_visit || cmd.clr_wr;
        vis_wdata = cmd.start || do_visit;
        if (cmd.clr_init)
        begin
            vis_waddr = sweep_reg[VW-1:0];
        end
        else if (cmd.start)
        begin
            vis_waddr = src_idx;
        end
        else if (cmd.clr_wr)
        begin
            vis_waddr = que_q;
        end
        else
        begin
            vis_waddr = w_idx;
        end

        que_we    = cmd.start || do_visit;
        que_waddr = cmd.start ? '0 : tail_reg[VW-1:0];
        que_wdata = cmd.start ? src_idx : w_idx;
        que_re    = cmd.pop || cmd.clr_rd;
        que_raddr = cmd.pop ? head_reg[VW-1:0] : sweep_reg[VW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (nbr_we)
        begin
            nbr_mem[nbr_waddr] <= item_reg.to_vertex;
        end
        if (cmd.nb_rd)
        begin
            nbr_q <= nbr_mem[{u_reg, k_reg[KW-1:0]}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (deg_re)
        begin
            deg_q <= deg_mem[deg_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (cmd.vis_rd)
        begin
            vis_q <= vis_mem[VW'(nbr_q)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (que_we)
        begin
            que_mem[que_waddr] <= que_wdata;
        end
        if (que_re)
        begin
            que_q <= que_mem[que_raddr];
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        sweep_next     = sweep_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;

        if (cmd.clr_init || cmd.clr_wr)
        begin
            sweep_next = sweep_reg + QW'(1);
        end
        if (cmd.set_oor)
        begin
            count_next  = '0;
            status_next = STATUS_RANGE;
        end
        if (cmd.edge_wr)
        begin
            count_next  = '0;
            status_next = deg_full ? STATUS_FULL : STATUS_OK;
        end
        if (cmd.start)
        begin
            head_next   = '0;
            tail_next   = QW'(1);
            sweep_next  = '0;
            count_next  = '0;
            status_next = STATUS_OK;
        end
        if (cmd.pop)
        begin
            head_next = head_reg + QW'(1);
        end
        if (cmd.nb_init)
        begin
            k_next = '0;
        end
        if (cmd.nb_rd)
        begin
            k_next = k_reg + DW'(1);
        end
        if (do_visit)
        begin
            tail_next = tail_reg + QW'(1);
            if (w_reg != '0 && count_reg != '1)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VCOUNT_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            sweep_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                vcount_reg <= cfg_data;
            end
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            sweep_reg     <= sweep_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.deg_rd)
        begin
            u_reg <= que_q;
        end
        if (cmd.nb_init)
        begin
            degu_reg <= deg_q;
        end
        if (cmd.vis_rd)
        begin
            w_reg <= nbr_q;
        end
        count_reg  <= count_next;
        status_reg <= status_next;
        if (cmd.out_load)
        begin
            out_reg.reached_count <= count_reg;
            out_reg.status        <= status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

[rtl/core/bre_ctrl.sv]
// ----------------------------------------------------------------------------
// bre_ctrl
// Sequencer for the reset sweep, edge loading, search walk, visited clear and result hand-off.
// ----------------------------------------------------------------------------
module bre_ctrl
    import bre_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  bre_sts_t sts,
    output bre_cmd_t cmd
);

    localparam logic [3:0] ST_INIT     = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DISPATCH = 4'd2;
    localparam logic [3:0] ST_EDGE_WR  = 4'd3;
    localparam logic [3:0] ST_POP      = 4'd4;
    localparam logic [3:0] ST_POP_WAIT = 4'd5;
    localparam logic [3:0] ST_DEG_WAIT = 4'd6;
    localparam logic [3:0] ST_NB_RD    = 4'd7;
    localparam logic [3:0] ST_NB_WAIT  = 4'd8;
    localparam logic [3:0] ST_VIS_WAIT = 4'd9;
    localparam logic [3:0] ST_CLR_RD   = 4'd10;
    localparam logic [3:0] ST_CLR_WR   = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    logic [3:0] state_reg, state_next;

    assign in_stall = state_reg != ST_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clr_init = 1'b1;
                if (sts.init_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.item_oor)
                begin
                    cmd.set_oor = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (sts.item_func == FUNC_SEARCH)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.edge_rd = 1'b1;
                    state_next  = ST_EDGE_WR;
                end
            end
            ST_EDGE_WR:
            begin
                cmd.edge_wr = 1'b1;
                state_next  = ST_DONE;
            end
            ST_POP:
            begin
                if (sts.queue_empty)
                begin
                    state_next = ST_CLR_RD;
                end
                else
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                cmd.deg_rd = 1'b1;
                state_next = ST_DEG_WAIT;
            end
            ST_DEG_WAIT:
            begin
                cmd.nb_init = 1'b1;
                state_next  = ST_NB_RD;
            end
            ST_NB_RD:
            begin
                if (sts.nb_done)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    cmd.nb_rd  = 1'b1;
                    state_next = ST_NB_WAIT;
                end
            end
            ST_NB_WAIT:
            begin
                if (sts.w_oor)
                begin
                    state_next = ST_NB_RD;
                end
                else
                begin
                    cmd.vis_rd = 1'b1;
                    state_next = ST_VIS_WAIT;
                end
            end
            ST_VIS_WAIT:
            begin
                cmd.visit  = 1'b1;
                state_next = ST_NB_RD;
            end
            ST_CLR_RD:
            begin
                if (sts.clr_done)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.clr_rd = 1'b1;
                    state_next = ST_CLR_WR;
                end
            end
            ST_CLR_WR:
            begin
                cmd.clr_wr = 1'b1;
                state_next = ST_CLR_RD;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/bfs_reachability_engine_core.sv]
// ----------------------------------------------------------------------------
// bfs_reachability_engine_core
// Breadth-first reachability over bounded adjacency lists.
//
// Input words: func 0 appends to_vertex to from_vertex's list, func 1 runs a
// search from source_vertex. Each input word gives one output word with
// reached_count and status. Write vertex_count on the cfg channel only while
// the block is idle.
// After reset the degree and visited stores are swept with in_stall high.
// Each input word holds in_stall high until its result is loaded, so a new
// word is taken only once the last one is through. A search pops each
// queued vertex, reads its degree, scans its neighbor slots and checks the
// in-range neighbors against the visited store; each store is read through
// a single port. The visited store is swept back over the queue at the end
// of each search.
// The output register holds a result while out_stall is high; the next word
// may be accepted meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module bfs_reachability_engine_core
    import bre_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = DEF_MAX_DEGREE
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bre_in_t             in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bre_out_t            out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [VCOUNT_W-1:0] cfg_data
);

    bre_cmd_t cmd;
    bre_sts_t sts;

    assign cfg_ready = 1'b1;

    bre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    bre_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data)
    );

endmodule

[tb/sv/tb_bfs_reachability_engine_core.sv]
// ----------------------------------------------------------------------------
// tb_bfs_reachability_engine_core
// Self-checking bench for the breadth-first reachability engine. A tracker
// keeps its own adjacency lists, degree counts and vertex count, predicts
// reached_count and status for every accepted input word, and compares each
// accepted output word in order. Stimulus: a chain over all vertices, directed
// range/full/stale cases, then random phases with random vertex counts,
// bursty input and a receiver that stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_bfs_reachability_engine_core;
    import bre_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 200000;
    localparam int RANDOM_WORDS = 200;
    localparam int IN_W         = $bits(bre_in_t);

    class reach_tracker;
        int unsigned         vertex_limit;
        logic [VERTEX_W-1:0] adj [DEF_MAX_VERTICES][DEF_MAX_DEGREE];
        int unsigned         degree [DEF_MAX_VERTICES];
        bre_out_t            results_due [$];
        int                  errors;

        function new();
            vertex_limit = 32'(VCOUNT_RESET);
            foreach (degree[i])
                degree[i] = 0;
            errors = 0;
        endfunction

        function void set_vertex_count(logic [VCOUNT_W-1:0] v);
            vertex_limit = (v > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES : v;
        endfunction

        function logic [COUNT_W-1:0] reach_from(int unsigned src, int unsigned n);
            bit          seen [DEF_MAX_VERTICES];
            int unsigned fifo [DEF_MAX_VERTICES];
            int unsigned head;
            int unsigned tail;
            int unsigned u;
            int unsigned w;
            int unsigned cnt;
            foreach (seen[i])
                seen[i] = 1'b0;
            cnt  = 0;
            head = 0;
            tail = 0;
            seen[src] = 1'b1;
            fifo[tail] = src;
            tail++;
            while (head < tail)
            begin
                u = fifo[head];
                head++;
                for (int k = 0; k < degree[u]; k++)
                begin
                    w = adj[u][k];
                    if (w >= n || seen[w])
                        continue;
                    seen[w] = 1'b1;
                    fifo[tail] = w;
                    tail++;
                    if (w != 0 && cnt < 255)
                        cnt++;
                end
            end
            return cnt[COUNT_W-1:0];
        endfunction

        function void accept_word(bre_in_t w);
            bre_out_t r;
            r.reached_count = '0;
            r.status        = STATUS_OK;
            if (w.func == FUNC_ADD_EDGE)
            begin
                if (w.from_vertex >= vertex_limit || w.to_vertex >= vertex_limit)
                    r.status = STATUS_RANGE;
                else if (degree[w.from_vertex] >= DEF_MAX_DEGREE)
                    r.status = STATUS_FULL;
                else
                begin
                    adj[w.from_vertex][degree[w.from_vertex]] = w.to_vertex;
                    degree[w.from_vertex]++;
                end
            end
            else if (w.source_vertex >= vertex_limit)
                r.status = STATUS_RANGE;
            else
                r.reached_count = reach_from(w.source_vertex, vertex_limit);
            results_due = {results_due, r};
        endfunction

        function void compare_word(bre_out_t got);
            bre_out_t want;
            if (results_due.size() == 0)
            begin
                $error("output word with none due: reached_count %0d status %0d",
                       got.reached_count, got.status);
                errors++;
                return;
            end
            want = results_due[0];
            results_due.delete(0);
            if (got.reached_count !== want.reached_count)
            begin
                $error("reached_count: expected %0d, actual %0d",
                       want.reached_count, got.reached_count);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    bre_in_t             in_data;
    logic                out_valid;
    logic                out_stall;
    bre_out_t            out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [VCOUNT_W-1:0] cfg_data;

    reach_tracker tracker;
    int           burst_left  = 0;
    int           stall_mode  = 0;
    int           stall_left  = 0;
    int unsigned  stall_tick  = 0;
    int           idle_cycles = 0;

    bfs_reachability_engine_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver: switches between free-running, random, periodic and heavy stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            stall_left <= 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(32, 300);
            end
            else
                stall_left <= stall_left - 1;
            stall_tick <= stall_tick + 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 2) == 0);
                2:       out_stall <= (stall_tick[2:0] < 3);
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.compare_word(out_data);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task send_word(input bre_in_t w);
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
        tracker.accept_word(w);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
        else
            burst_left--;
    endtask

    task add_edge(input int unsigned from_v, input int unsigned to_v);
        bre_in_t w;
        w               = IN_W'($urandom);
        w.func          = FUNC_ADD_EDGE;
        w.from_vertex   = VERTEX_W'(from_v);
        w.to_vertex     = VERTEX_W'(to_v);
        send_word(w);
    endtask

    task search(input int unsigned src);
        bre_in_t w;
        w               = IN_W'($urandom);
        w.func          = FUNC_SEARCH;
        w.source_vertex = VERTEX_W'(src);
        send_word(w);
    endtask

    // all results in and the block ready for input again
    task settle;
        in_valid <= 1'b0;
        while (tracker.results_due.size() != 0)
            @(posedge clk);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task write_vertex_count(input logic [VCOUNT_W-1:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_vertex_count(v);
    endtask

    task random_word(input int unsigned n);
        bre_in_t     w;
        int unsigned pick;
        w    = IN_W'($urandom);
        pick = $urandom_range(0, 99);
        if (n == 0 || pick >= 93)
            send_word(w);
        else if (pick < 65)
            add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
        else if (pick < 75)
        begin
            w.func = FUNC_ADD_EDGE;
            send_word(w);
        end
        else
            search($urandom_range(0, n - 1));
    endtask

    initial
    begin
        int unsigned vc;
        int unsigned sent;
        tracker   = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // chain over every vertex, reaching all 255 nonzero vertices
        write_vertex_count(9'd256);
        for (int i = 0; i < DEF_MAX_VERTICES - 1; i++)
            add_edge(i, i + 1);
        search(0);
        search(254);
        search(255);

        // count above the vertex range saturates; fill vertex 7 to overflow
        write_vertex_count(9'd511);
        add_edge(7, 0);
        add_edge(7, 255);
        add_edge(7, 100);
        add_edge(7, 200);
        add_edge(7, 7);
        add_edge(7, 3);
        add_edge(7, 9);
        add_edge(7, 1);
        search(7);
        search(0);

        write_vertex_count(9'd0);
        add_edge(0, 0);
        add_edge(255, 255);
        search(0);

        write_vertex_count(9'd1);
        add_edge(0, 0);
        search(0);
        add_edge(0, 1);
        add_edge(1, 0);
        search(1);

        // stale neighbors above the lowered count
        write_vertex_count(9'd8);
        add_edge(7, 200);
        add_edge(7, 2);
        search(0);
        search(3);

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0:       vc = $urandom_range(0, 1);
                1:       vc = $urandom_range(256, 511);
                2:       vc = $urandom_range(0, 511);
                default: vc = $urandom_range(2, 48);
            endcase
            write_vertex_count(VCOUNT_W'(vc));
            if (vc > DEF_MAX_VERTICES)
                vc = DEF_MAX_VERTICES;
            repeat ($urandom_range(10, 50))
            begin
                random_word(vc);
                sent++;
            end
        end

        settle();
        repeat (300) @(posedge clk);
        if (tracker.errors == 0 && tracker.results_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
